/* hw/rtl/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window maximum core.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int LEN_W        = 7;
  localparam int CNT_W        = (LEN_W > $clog2(MAX_WINDOW + 1)) ? LEN_W
                                                                 : $clog2(MAX_WINDOW + 1);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [LEN_W-1:0]               len_t;

  // broadcast to every cell
  typedef struct packed {
    logic    step;
    logic    clear;
    logic    shift;
    sample_t sample;
  } swm_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    sample_t value;
    cnt_t    age;
    logic    valid;
    logic    keep;
  } swm_link_t;

endpackage

/* hw/rtl/swm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One deque entry: holds a sample and its age, compares against the new
// sample and takes its right neighbor's entry when the front expires.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::swm_ctrl_t ctrl,
  input  swm_pkg::swm_link_t rt_link,
  input  logic               lf_src_keep,
  output swm_pkg::swm_link_t link,
  output logic               src_keep
);
  import swm_pkg::*;

  sample_t value_r, value_nxt;
  cnt_t    age_r, age_nxt;
  logic    valid_r, valid_nxt;
  sample_t src_value;
  cnt_t    src_age;
  logic    insert;

  always_comb begin
    link.value = value_r;
    link.age   = age_r;
    link.valid = valid_r;
    link.keep  = valid_r && !ctrl.clear && (value_r > ctrl.sample);

    src_value = ctrl.shift ? rt_link.value : value_r;
    src_age   = ctrl.shift ? rt_link.age   : age_r;
    src_keep  = ctrl.shift ? rt_link.keep  : link.keep;
    insert    = !src_keep && lf_src_keep;

    value_nxt = value_r;
    age_nxt   = age_r;
    valid_nxt = valid_r;
    if (ctrl.step) begin
      if (src_keep) begin
        value_nxt = src_value;
        age_nxt   = (src_age == '1) ? src_age : src_age + cnt_t'(1);
        valid_nxt = 1'b1;
      end else if (insert) begin
        value_nxt = ctrl.sample;
        age_nxt   = '0;
        valid_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      age_r   <= age_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* hw/rtl/sliding_window_max_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_core
// Running maximum over the last window_len signed samples, held as a
// monotonic deque in a chain of cells.
// ----------------------------------------------------------------------------
// the result is registered and presented in the cycle after its input transaction
// throughput: 1 transaction per cycle when not stalled, set by the cell chain update
// input stalls only while a finished result waits on a stalled output
// reset: deque and fill count cleared, window_len back to 3, no clearing pass
module sliding_window_max_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  swm_pkg::len_t        cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swm_pkg::sample_t     in_sample,
  input  logic                 in_stream_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swm_pkg::sample_t     out_window_max
);
  import swm_pkg::*;

  len_t      len_r;
  cnt_t      fill_r, fill_nxt;
  logic      out_valid_r, out_valid_nxt;
  sample_t   out_max_r, out_max_nxt;
  cnt_t      len_eff;
  logic      accept;
  logic      result;
  swm_ctrl_t ctrl;
  swm_link_t link [MAX_WINDOW+1];
  logic      skeep [MAX_WINDOW+1];
  logic      [MAX_WINDOW-1:0] valid_vec;
  swm_link_t front_src;
  cnt_t      fill_base;

  assign link[MAX_WINDOW] = '{value: '0, age: '0, valid: 1'b0, keep: 1'b0};
  assign skeep[0]         = 1'b1;

  genvar g;
  generate
    for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
      swm_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .rt_link     (link[g+1]),
        .lf_src_keep (skeep[g]),
        .link        (link[g]),
        .src_keep    (skeep[g+1])
      );
      assign valid_vec[g] = link[g].valid;
    end
  endgenerate

  assign in_stall       = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

  always_comb begin
    len_eff = (cnt_t'(len_r) > cnt_t'(MAX_WINDOW)) ? cnt_t'(MAX_WINDOW) : cnt_t'(len_r);
    accept  = in_valid && !in_stall;

    ctrl.sample = in_sample;
    ctrl.clear  = cfg_wr_en || (accept && in_stream_start);
    ctrl.step   = accept && (len_eff != '0);
    ctrl.shift  = link[0].valid && !in_stream_start &&
                  ((link[0].age + cnt_t'(1)) >= len_eff);

    front_src = ctrl.shift ? link[1] : link[0];

    // fill count with stream start folded in
    fill_base = in_stream_start ? '0 : fill_r;
    fill_nxt  = fill_r;
    result    = 1'b0;
    if (cfg_wr_en) begin
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = fill_base;
      if (len_eff != '0) begin
        if (fill_base < len_eff) begin
          fill_nxt = fill_base + cnt_t'(1);
        end
        result = (fill_nxt >= len_eff);
      end
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_max_nxt   = out_max_r;
    if (result) begin
      out_valid_nxt = 1'b1;
      out_max_nxt   = skeep[1] ? front_src.value : in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_max_r <= out_max_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_t'(MAX_WINDOW))
    else $error("fill count beyond window");

  a_front_age: assert property (@(posedge clk) disable iff (!rst_n)
    link[0].valid |-> (link[0].age < len_eff))
    else $error("front entry older than window");

  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    !link[0].valid |-> ($countones(valid_vec) == 0))
    else $error("deque entries not contiguous from front");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    result |=> out_valid_r)
    else $error("result transaction lost");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sliding_window_max_core. A sample-by-sample model of
// the monotonic deque predicts each window maximum. Every result is compared
// in order against it, while both channels idle and stall at random, the
// window length is rewritten between phases, and the output is held off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 4;

  logic    clk             = 1'b0;
  logic    rst_n           = 1'b0;
  logic    cfg_wr_en       = 1'b0;
  len_t    cfg_wr_data     = '0;
  logic    in_valid        = 1'b0;
  logic    in_stall;
  sample_t in_sample       = '0;
  logic    in_stream_start = 1'b0;
  logic    out_valid;
  logic    out_stall       = 1'b0;
  sample_t out_window_max;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_go        = 1'b0;
  int          hold_left      = 0;
  int          cycle_cnt      = 0;
  int          error_cnt      = 0;
  int          sample_cnt     = 0;
  int          result_cnt     = 0;
  int          window_writes  = 0;

  len_t    win_len;
  sample_t deque_val[$];
  int      deque_age[$];
  int      fill_cnt;
  sample_t window_max_q[$];

  sliding_window_max_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_stream_start(in_stream_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_deque();
    deque_val.delete();
    deque_age.delete();
    fill_cnt = 0;
  endfunction

  function automatic void predict_window_max(input sample_t s, input logic st);
    int eff;
    if (st) clear_deque();
    if (win_len == 0) return;
    eff = (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
    foreach (deque_age[i]) begin
      if (deque_age[i] < 127) deque_age[i]++;
    end
    while (deque_age.size() != 0 && deque_age[0] >= eff) begin
      deque_val.delete(0);
      deque_age.delete(0);
    end
    while (deque_val.size() != 0 && deque_val[$] <= s) begin
      deque_val.delete(deque_val.size() - 1);
      deque_age.delete(deque_age.size() - 1);
    end
    deque_val.insert(deque_val.size(), s);
    deque_age.insert(deque_age.size(), 0);
    if (fill_cnt < eff) fill_cnt++;
    if (fill_cnt >= eff) window_max_q.insert(window_max_q.size(), deque_val[0]);
  endfunction

  // result check, then register and input transactions of this edge
  always @(posedge clk) begin : check_results
    sample_t expected_max;
    if (!rst_n) begin
      win_len = LEN_RESET;
      clear_deque();
      window_max_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (window_max_q.size() == 0) begin
          $display("%0t: window_max expected none got %0d", $time, out_window_max);
          error_cnt++;
        end else begin
          expected_max = window_max_q[0];
          window_max_q.delete(0);
          if (out_window_max !== expected_max) begin
            $display("%0t: window_max expected %0d got %0d", $time, expected_max,
                     out_window_max);
            error_cnt++;
          end else begin
            result_cnt++;
          end
        end
      end
      if (cfg_wr_en) begin
        win_len = cfg_wr_data;
        clear_deque();
      end
      if (in_valid && !in_stall) begin
        sample_cnt++;
        predict_window_max(in_sample, in_stream_start);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall <= hold_go || hold_left > 1 || $urandom_range(99) < sink_stall_pct;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               window_max_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s, input logic st);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_stream_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle_input();
    in_valid <= 1'b0;
    @(posedge clk);
    while (window_max_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input len_t w);
    settle_input();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    window_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned src, input int unsigned sink);
    src_idle_pct   <= src;
    sink_stall_pct <= sink;
  endtask

  function automatic sample_t next_sample(input int style, input sample_t prev);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(6)) - 3);
      2: return prev - sample_t'($urandom_range(3));
      3: return prev + sample_t'($urandom_range(3));
      default: return $urandom_range(1) ? sample_t'(32'h7fff_ffff) : sample_t'(32'h8000_0000);
    endcase
  endfunction

  function automatic len_t pick_window();
    case ($urandom_range(15))
      0: return len_t'(1);
      1: return len_t'(MAX_WINDOW);
      2: return len_t'(127);
      3: return len_t'($urandom_range(65, 126));
      4: return len_t'($urandom_range(20, 63));
      default: return len_t'($urandom_range(2, 10));
    endcase
  endfunction

  // mostly full streams, some cut short, some without the start flag
  task automatic send_stream(input int eff, input bit broken);
    int      n;
    int      style;
    sample_t v;
    n     = broken ? $urandom_range(eff, 1) : eff + $urandom_range(2 * eff + 8);
    style = $urandom_range(4);
    v     = sample_t'($urandom);
    for (int k = 0; k < n; k++) begin
      v = next_sample(style, v);
      send_sample(v, k == 0 && $urandom_range(9) != 0);
    end
  endtask

  task automatic test_default_window();
    set_idling(0, 0);
    send_sample(sample_t'(32'h7fff_ffff), 1'b1);
    send_sample(sample_t'(32'h8000_0000), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-7), 1'b1);
    send_sample(sample_t'(-8), 1'b0);
    send_sample(sample_t'(-9), 1'b0);
    settle_input();
  endtask

  task automatic test_window_edges();
    write_window(len_t'(0));
    send_sample(sample_t'(32'h8000_0000), 1'b1);
    send_sample(sample_t'(32'h7fff_ffff), 1'b0);
    send_sample(sample_t'(3), 1'b1);
    write_window(len_t'(1));
    send_sample(sample_t'(32'h8000_0000), 1'b0);
    send_sample(sample_t'(32'h7fff_ffff), 1'b0);
    send_sample(sample_t'(-2), 1'b1);
    send_sample(sample_t'(-2), 1'b0);
    write_window(len_t'(127));
    send_sample(sample_t'(32'h5555_aaaa), 1'b1);
    send_sample(sample_t'(32'haaaa_5555), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    settle_input();
  endtask

  task automatic test_output_hold();
    write_window(len_t'(4));
    set_idling(0, 0);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int k = 0; k < 40; k++) send_sample(sample_t'($urandom), k == 0);
    settle_input();
  endtask

  task automatic test_random_phase(input int items, input int unsigned src,
                                   input int unsigned sink);
    int   start_cnt;
    int   eff;
    len_t w;
    set_idling(src, sink);
    start_cnt = sample_cnt;
    while (sample_cnt - start_cnt < items) begin
      w   = pick_window();
      eff = (w > MAX_WINDOW) ? MAX_WINDOW : int'(w);
      write_window(w);
      repeat ((eff >= 32) ? 1 : $urandom_range(2, 5)) send_stream(eff, $urandom_range(9) == 0);
    end
    settle_input();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_window();
    test_window_edges();
    test_output_hold();
    test_random_phase(110, 0, 0);
    test_random_phase(110, 63, 0);
    test_random_phase(110, 0, 63);
    test_random_phase(110, 20, 20);
    $display("run: %0d samples sent, %0d window maxima matched, %0d window writes",
             sample_cnt, result_cnt, window_writes);
    $display("run: %0d cycles, idle and stall phases plus one long output hold",
             cycle_cnt);
    if (error_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
